@@ rtl/core/avr_pkg.sv @@
// Shared types and constants for the axis-angle vector rotate core.
// No dependencies; used by every module in rtl/core.
package avr_pkg;

	localparam int CordicSteps = 20;
	localparam int CordicW     = 34;
	localparam logic signed [CordicW-1:0] CordicStart = 34'sd652032874;

	typedef struct packed {
		logic signed [17:0] axis_x;
		logic signed [17:0] axis_y;
		logic signed [17:0] axis_z;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
	} item_t;

	typedef struct packed {
		logic signed [CordicW-1:0] x;
		logic signed [CordicW-1:0] y;
		logic signed [CordicW-1:0] z;
		logic                      flip;
		item_t                     item;
	} cordic_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [30:0] atan_step(input int i);
		logic [30:0] r;
		case (i)
			0:  r = 31'd536870912;
			1:  r = 31'd316933406;
			2:  r = 31'd167458907;
			3:  r = 31'd85004756;
			4:  r = 31'd42667331;
			5:  r = 31'd21354465;
			6:  r = 31'd10679838;
			7:  r = 31'd5340245;
			8:  r = 31'd2670163;
			9:  r = 31'd1335087;
			10: r = 31'd667544;
			11: r = 31'd333772;
			12: r = 31'd166886;
			13: r = 31'd83443;
			14: r = 31'd41722;
			15: r = 31'd20861;
			16: r = 31'd10430;
			17: r = 31'd5215;
			18: r = 31'd2608;
			19: r = 31'd1304;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/avr_cordic_cell.sv @@
// One CORDIC rotation step as a pipeline cell; payload rides along.
// Depends on avr_pkg.
module avr_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  avr_pkg::cordic_t in_data,
	output logic             out_valid,
	output avr_pkg::cordic_t out_data
);

	localparam logic signed [avr_pkg::CordicW-1:0] Atan =
		$signed({{(avr_pkg::CordicW-31){1'b0}}, avr_pkg::atan_step(STEP)});

	logic signed [avr_pkg::CordicW-1:0] dx, dy;
	avr_pkg::cordic_t nxt;

	assign dx = in_data.y >>> STEP;
	assign dy = in_data.x >>> STEP;

	always_comb begin
		nxt = in_data;
		if (!in_data.z[avr_pkg::CordicW-1]) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - Atan;
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + Atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

@@ rtl/core/avr_matrix.sv @@
// Rounds cos/sin, builds the rotation matrix and applies it to the vector.
// Six-stage pipeline; depends on avr_pkg.
module avr_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  avr_pkg::cordic_t   in_data,
	output logic               done,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z
);

	// stage 1: cos, sin to Q1.16
	logic signed [avr_pkg::CordicW-1:0] cr, sr;
	logic signed [17:0] c_cl, s_cl;
	logic signed [17:0] c_s1, s_s1;
	avr_pkg::item_t it_s1;
	logic v_s1;

	assign cr = (in_data.x + 34'sd8192) >>> 14;
	assign sr = (in_data.y + 34'sd8192) >>> 14;

	always_comb begin
		if (cr > 34'sd65536)       c_cl = 18'sd65536;
		else if (cr < -34'sd65536) c_cl = -18'sd65536;
		else                       c_cl = cr[17:0];
		if (sr > 34'sd65536)       s_cl = 18'sd65536;
		else if (sr < -34'sd65536) s_cl = -18'sd65536;
		else                       s_cl = sr[17:0];
	end

	always_ff @(posedge clk) begin
		c_s1  <= in_data.flip ? -c_cl : c_cl;
		s_s1  <= in_data.flip ? -s_cl : s_cl;
		it_s1 <= in_data.item;
	end

	// stage 2: axis products, sine terms, t
	logic signed [35:0] xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2;
	logic signed [35:0] xs_s2, ys_s2, zs_s2;
	logic signed [18:0] t_s2;
	logic signed [17:0] c_s2;
	avr_pkg::item_t it_s2;
	logic v_s2;

	always_ff @(posedge clk) begin
		xx_s2 <= it_s1.axis_x * it_s1.axis_x;
		yy_s2 <= it_s1.axis_y * it_s1.axis_y;
		zz_s2 <= it_s1.axis_z * it_s1.axis_z;
		xy_s2 <= it_s1.axis_x * it_s1.axis_y;
		xz_s2 <= it_s1.axis_x * it_s1.axis_z;
		yz_s2 <= it_s1.axis_y * it_s1.axis_z;
		xs_s2 <= it_s1.axis_x * s_s1;
		ys_s2 <= it_s1.axis_y * s_s1;
		zs_s2 <= it_s1.axis_z * s_s1;
		t_s2  <= 19'sd65536 - {c_s1[17], c_s1};
		c_s2  <= c_s1;
		it_s2 <= it_s1;
	end

	// stage 3: u*v*t floored to Q.32
	logic signed [54:0] pxx, pyy, pzz, pxy, pxz, pyz;
	logic signed [38:0] xxt_s3, yyt_s3, zzt_s3, xyt_s3, xzt_s3, yzt_s3;
	logic signed [35:0] xs_s3, ys_s3, zs_s3;
	logic signed [17:0] c_s3;
	avr_pkg::item_t it_s3;
	logic v_s3;

	assign pxx = xx_s2 * t_s2;
	assign pyy = yy_s2 * t_s2;
	assign pzz = zz_s2 * t_s2;
	assign pxy = xy_s2 * t_s2;
	assign pxz = xz_s2 * t_s2;
	assign pyz = yz_s2 * t_s2;

	always_ff @(posedge clk) begin
		xxt_s3 <= pxx[54:16];
		yyt_s3 <= pyy[54:16];
		zzt_s3 <= pzz[54:16];
		xyt_s3 <= pxy[54:16];
		xzt_s3 <= pxz[54:16];
		yzt_s3 <= pyz[54:16];
		xs_s3  <= xs_s2;
		ys_s3  <= ys_s2;
		zs_s3  <= zs_s2;
		c_s3   <= c_s2;
		it_s3  <= it_s2;
	end

	// stage 4: matrix entries rounded to Q.24
	logic signed [40:0] cc, e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [40:0] q00, q01, q02, q10, q11, q12, q20, q21, q22;
	logic signed [32:0] m00_s4, m01_s4, m02_s4, m10_s4, m11_s4, m12_s4;
	logic signed [32:0] m20_s4, m21_s4, m22_s4;
	avr_pkg::item_t it_s4;
	logic v_s4;

	always_comb begin
		cc  = 41'(c_s3) <<< 16;
		e00 = cc + 41'(xxt_s3);
		e01 = 41'(xyt_s3) - 41'(zs_s3);
		e02 = 41'(xzt_s3) + 41'(ys_s3);
		e10 = 41'(xyt_s3) + 41'(zs_s3);
		e11 = cc + 41'(yyt_s3);
		e12 = 41'(yzt_s3) - 41'(xs_s3);
		e20 = 41'(xzt_s3) - 41'(ys_s3);
		e21 = 41'(yzt_s3) + 41'(xs_s3);
		e22 = cc + 41'(zzt_s3);
		q00 = (e00 + 41'sd128) >>> 8;
		q01 = (e01 + 41'sd128) >>> 8;
		q02 = (e02 + 41'sd128) >>> 8;
		q10 = (e10 + 41'sd128) >>> 8;
		q11 = (e11 + 41'sd128) >>> 8;
		q12 = (e12 + 41'sd128) >>> 8;
		q20 = (e20 + 41'sd128) >>> 8;
		q21 = (e21 + 41'sd128) >>> 8;
		q22 = (e22 + 41'sd128) >>> 8;
	end

	always_ff @(posedge clk) begin
		m00_s4 <= q00[32:0];
		m01_s4 <= q01[32:0];
		m02_s4 <= q02[32:0];
		m10_s4 <= q10[32:0];
		m11_s4 <= q11[32:0];
		m12_s4 <= q12[32:0];
		m20_s4 <= q20[32:0];
		m21_s4 <= q21[32:0];
		m22_s4 <= q22[32:0];
		it_s4  <= it_s3;
	end

	// stage 5: matrix times vector
	logic signed [64:0] p00_s5, p01_s5, p02_s5, p10_s5, p11_s5, p12_s5;
	logic signed [64:0] p20_s5, p21_s5, p22_s5;
	logic v_s5;

	always_ff @(posedge clk) begin
		p00_s5 <= m00_s4 * it_s4.vec_x;
		p01_s5 <= m01_s4 * it_s4.vec_y;
		p02_s5 <= m02_s4 * it_s4.vec_z;
		p10_s5 <= m10_s4 * it_s4.vec_x;
		p11_s5 <= m11_s4 * it_s4.vec_y;
		p12_s5 <= m12_s4 * it_s4.vec_z;
		p20_s5 <= m20_s4 * it_s4.vec_x;
		p21_s5 <= m21_s4 * it_s4.vec_y;
		p22_s5 <= m22_s4 * it_s4.vec_z;
	end

	// stage 6: row sums, round, saturate
	function automatic logic signed [31:0] row_sat(input logic signed [66:0] s);
		logic signed [66:0] r;
		logic signed [31:0] o;
		r = (s + 67'sd8388608) >>> 24;
		if (r > 67'sd2147483647)       o = 32'sh7fffffff;
		else if (r < -67'sd2147483648) o = 32'sh80000000;
		else                           o = r[31:0];
		return o;
	endfunction

	always_ff @(posedge clk) begin
		rot_x <= row_sat(67'(p00_s5) + 67'(p01_s5) + 67'(p02_s5));
		rot_y <= row_sat(67'(p10_s5) + 67'(p11_s5) + 67'(p12_s5));
		rot_z <= row_sat(67'(p20_s5) + 67'(p21_s5) + 67'(p22_s5));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			done <= v_s5;
		end
	end

endmodule

@@ rtl/core/axis_angle_vector_rotate_core.sv @@
// Top level of the axis-angle vector rotate core.
// Depends on avr_pkg, avr_cordic_cell and avr_matrix.
//
// Fully pipelined: a transaction is taken on every cycle that start is high
// (busy is always low), and its rotated vector appears with done high after
// passing 20 CORDIC cells, one per step, then six matrix stages.
// Results are shown for one cycle only and cannot be held off, so the
// receiver must take every cycle that done is high.
module axis_angle_vector_rotate_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [17:0] axis_x,
	input  logic signed [17:0] axis_y,
	input  logic signed [17:0] axis_z,
	input  logic        [15:0] turn_angle,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	output logic               done,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z
);

	logic [31:0] ang, ang_f;
	logic [31:0] add_q;
	logic        flip;
	avr_pkg::cordic_t head;

	logic             cv [avr_pkg::CordicSteps+1];
	avr_pkg::cordic_t cd [avr_pkg::CordicSteps+1];

	assign busy  = 1'b0;
	assign ang   = {turn_angle, 16'h0000};
	assign add_q = ang + 32'h4000_0000;
	// second and third quadrants: move by half a turn, negate at the end
	assign flip  = add_q[31];
	assign ang_f = flip ? ang + 32'h8000_0000 : ang;

	always_comb begin
		head.x           = avr_pkg::CordicStart;
		head.y           = '0;
		head.z           = avr_pkg::CordicW'($signed(ang_f));
		head.flip        = flip;
		head.item.axis_x = axis_x;
		head.item.axis_y = axis_y;
		head.item.axis_z = axis_z;
		head.item.vec_x  = vec_x;
		head.item.vec_y  = vec_y;
		head.item.vec_z  = vec_z;
	end

	assign cv[0] = start & ~busy;
	assign cd[0] = head;

	for (genvar g = 0; g < avr_pkg::CordicSteps; g++) begin : g_cell
		avr_cordic_cell #(.STEP(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[g]),
			.in_data  (cd[g]),
			.out_valid(cv[g+1]),
			.out_data (cd[g+1])
		);
	end

	avr_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cv[avr_pkg::CordicSteps]),
		.in_data (cd[avr_pkg::CordicSteps]),
		.done    (done),
		.rot_x   (rot_x),
		.rot_y   (rot_y),
		.rot_z   (rot_z)
	);

endmodule
